### src/pclf_pkg.sv
// shared constants, types and status codes of the page cache lookup and fill block
package pclf_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int TIER_BITS_DEF = 3;

	localparam int INODE_W  = 32;
	localparam int OFFSET_W = 32;
	localparam int TIER_W   = 3;
	localparam int FRAME_W  = 20;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;

	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FILLED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOFRAME  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FILLFAIL = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic fin_hit;
		logic fin_miss;
	} pclf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic scan_done;
		logic out_free;
	} pclf_stat_t;

endpackage

### src/pclf_ifs.sv
// request and result channel interfaces
interface pclf_req_if;
	import pclf_pkg::*;

	logic                valid;
	logic                ready;
	logic [INODE_W-1:0]  inode_number;
	logic [OFFSET_W-1:0] page_offset;
	logic [TIER_W-1:0]   tier;
	logic [FRAME_W-1:0]  new_frame;
	logic                fill_ok;

	modport source (
		output valid, inode_number, page_offset, tier, new_frame, fill_ok,
		input  ready
	);
	modport sink (
		input  valid, inode_number, page_offset, tier, new_frame, fill_ok,
		output ready
	);
endinterface

interface pclf_rsp_if;
	import pclf_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [FRAME_W-1:0]  frame_number;
	logic                release_frame;

	modport source (
		output valid, status, slot_index, frame_number, release_frame,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, frame_number, release_frame,
		output ready
	);
endinterface

### src/page_cache_lookup_fill.sv
// top level of the page cache lookup and fill block
// usage:
// - req channel: one transfer per lookup, carrying the inode number and page
//   offset key, the tier tag, the frame offered for a miss and the fill result
// - rsp channel: exactly one transfer per request with status, slot, frame and
//   the release flag for a failed fill
// - entries are filled in slot order and never evicted, so the valid entries
//   are always slots 0 to count-1 and the lowest free slot is the fill count
// - the tag store is scanned one slot per cycle through its registered read
//   port; a hit ends the scan at the lowest matching slot, and a miss reads
//   all count filled slots before its result is committed
// - one request is worked on at a time; req.ready is high only while idle,
//   from the cycle the last result appears, even while that result still waits
// - when the receiver stalls the finished result holds in the output register
//   and the controller waits before committing the next one
// - reset clears the fill count, so the cache starts empty with no clearing
//   pass; the store contents need no reset
module page_cache_lookup_fill #(
	parameter int SLOTS     = pclf_pkg::SLOTS_DEF,
	parameter int TIER_BITS = pclf_pkg::TIER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pclf_req_if.sink      req,
	pclf_rsp_if.source    rsp
);
	import pclf_pkg::*;

	pclf_cmd_t  cmd;
	pclf_stat_t stat;

	// sequencing: idle, scan, then commit a hit or a miss
	pclf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// tag store, compare pipeline and result register
	pclf_datapath #(
		.SLOTS     (SLOTS),
		.TIER_BITS (TIER_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_inode    (req.inode_number),
		.in_offset   (req.page_offset),
		.in_tier     (req.tier),
		.in_frame    (req.new_frame),
		.in_fill_ok  (req.fill_ok),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_slot    (rsp.slot_index),
		.out_frame   (rsp.frame_number),
		.out_release (rsp.release_frame)
	);

endmodule

### src/pclf_datapath.sv
// tag store, scan pipeline, fill counter and result register
module pclf_datapath #(
	parameter int SLOTS     = pclf_pkg::SLOTS_DEF,
	parameter int TIER_BITS = pclf_pkg::TIER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pclf_pkg::INODE_W-1:0]    in_inode,
	input  logic [pclf_pkg::OFFSET_W-1:0]   in_offset,
	input  logic [pclf_pkg::TIER_W-1:0]     in_tier,
	input  logic [pclf_pkg::FRAME_W-1:0]    in_frame,
	input  logic                            in_fill_ok,
	input  pclf_pkg::pclf_cmd_t             cmd,
	output pclf_pkg::pclf_stat_t            stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pclf_pkg::STATUS_W-1:0]   out_status,
	output logic [pclf_pkg::SLOT_W-1:0]     out_slot,
	output logic [pclf_pkg::FRAME_W-1:0]    out_frame,
	output logic                            out_release
);
	import pclf_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef struct packed {
		logic [INODE_W-1:0]  inode;
		logic [OFFSET_W-1:0] offset;
		logic [FRAME_W-1:0]  frame;
	} entry_t;

	entry_t               key_mem [SLOTS];
	logic [TIER_BITS-1:0] tier_mem [SLOTS];

	logic [INODE_W-1:0]  req_inode_q;
	logic [OFFSET_W-1:0] req_offset_q;
	logic [TIER_W-1:0]   req_tier_q;
	logic [FRAME_W-1:0]  req_frame_q;
	logic                req_ok_q;

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;
	logic           rd_en_s1;
	logic [AW-1:0]  rd_idx_s1;
	entry_t         rd_entry_s1;
	logic [AW-1:0]  hit_slot_q;
	logic [FRAME_W-1:0] hit_frame_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                release_q;

	logic                  issue;
	logic                  match_s1;
	logic                  full;
	logic                  no_frame;
	logic                  do_fill;
	logic [AW-1:0]         fill_slot;
	logic [TIER_W+TIER_BITS-1:0] tier_ext;
	logic [TIER_BITS-1:0]  tier_kept;
	logic [AW+SLOT_W-1:0]  hit_slot_ext;
	logic [AW+SLOT_W-1:0]  fill_slot_ext;

	assign issue     = cmd.scan && (idx_q < count_q);
	assign match_s1  = rd_en_s1 && (rd_entry_s1.inode == req_inode_q)
		&& (rd_entry_s1.offset == req_offset_q);
	assign full      = (count_q == CW'(SLOTS));
	assign no_frame  = (req_frame_q == '0);
	assign do_fill   = cmd.fin_miss && !full && !no_frame && req_ok_q;
	assign fill_slot = count_q[AW-1:0];

	// keep the low tier bits, zero-extend when the store is wider
	assign tier_ext      = {{TIER_BITS{1'b0}}, req_tier_q};
	assign tier_kept     = tier_ext[TIER_BITS-1:0];
	assign hit_slot_ext  = {{SLOT_W{1'b0}}, hit_slot_q};
	assign fill_slot_ext = {{SLOT_W{1'b0}}, fill_slot};

	assign stat.hit       = match_s1;
	assign stat.scan_done = (idx_q == count_q) && !rd_en_s1;
	assign stat.out_free  = !out_valid_q || out_ready;

	// tag store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_entry_s1 <= key_mem[idx_q[AW-1:0]];
			rd_idx_s1   <= idx_q[AW-1:0];
		end
		if (do_fill) begin
			key_mem[fill_slot] <= '{inode: req_inode_q, offset: req_offset_q,
				frame: req_frame_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_hit) begin
			tier_mem[hit_slot_q] <= tier_kept;
		end else if (do_fill) begin
			tier_mem[fill_slot] <= tier_kept;
		end
	end

	// request, hit capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_inode_q  <= in_inode;
			req_offset_q <= in_offset;
			req_tier_q   <= in_tier;
			req_frame_q  <= in_frame;
			req_ok_q     <= in_fill_ok;
		end
		if (cmd.scan && match_s1) begin
			hit_slot_q  <= rd_idx_s1;
			hit_frame_q <= rd_entry_s1.frame;
		end
		if (cmd.fin_hit) begin
			status_q  <= ST_HIT;
			slot_q    <= hit_slot_ext[SLOT_W-1:0];
			frame_q   <= hit_frame_q;
			release_q <= 1'b0;
		end else if (cmd.fin_miss) begin
			slot_q    <= '0;
			frame_q   <= '0;
			release_q <= 1'b0;
			if (full) begin
				status_q <= ST_FULL;
			end else if (no_frame) begin
				status_q <= ST_NOFRAME;
			end else if (!req_ok_q) begin
				status_q  <= ST_FILLFAIL;
				release_q <= 1'b1;
			end else begin
				status_q <= ST_FILLED;
				slot_q   <= fill_slot_ext[SLOT_W-1:0];
				frame_q  <= req_frame_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_en_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_en_s1 <= issue;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (do_fill) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.fin_hit || cmd.fin_miss) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = status_q;
	assign out_slot    = slot_q;
	assign out_frame   = frame_q;
	assign out_release = release_q;

endmodule

### src/pclf_ctrl.sv
// controller state machine sequencing accept, scan and result
module pclf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output pclf_pkg::pclf_cmd_t   cmd,
	input  pclf_pkg::pclf_stat_t  stat
);
	import pclf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_HIT  = 2'd2;
	localparam logic [1:0] S_MISS = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					state_d = S_HIT;
				end else if (stat.scan_done) begin
					state_d = S_MISS;
				end
			end
			S_HIT: begin
				if (stat.out_free) begin
					cmd.fin_hit = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_MISS: begin
				if (stat.out_free) begin
					cmd.fin_miss = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the page cache lookup and fill block
module tb;
	import pclf_pkg::*;

	localparam int CACHE_SLOTS   = SLOTS_DEF;
	localparam int TOTAL_LOOKUPS = 700;
	// the idling pattern changes every third of the run
	localparam int PHASE_LEN     = 233;
	// worst lookup is a full scan plus the pipeline and controller overhead
	localparam int DRAIN_CYCLES  = CACHE_SLOTS + 8;
	localparam int MAX_PRINTS    = 200;

	typedef struct packed {
		logic [INODE_W-1:0]  inode_number;
		logic [OFFSET_W-1:0] page_offset;
		logic [TIER_W-1:0]   tier;
		logic [FRAME_W-1:0]  new_frame;
		logic                fill_ok;
	} lookup_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
		logic [FRAME_W-1:0]  frame_number;
		logic                release_frame;
	} lookup_rsp_t;

	logic clk;
	logic arst_n;

	pclf_req_if req_ch ();
	pclf_rsp_if rsp_ch ();

	page_cache_lookup_fill #(
		.SLOTS     (CACHE_SLOTS),
		.TIER_BITS (TIER_BITS_DEF)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the tag store
	logic                model_valid  [CACHE_SLOTS];
	logic [INODE_W-1:0]  model_inode  [CACHE_SLOTS];
	logic [OFFSET_W-1:0] model_offset [CACHE_SLOTS];
	logic [FRAME_W-1:0]  model_frame  [CACHE_SLOTS];
	logic [TIER_W-1:0]   model_tier   [CACHE_SLOTS];
	int                  fill_count;

	// results owed by the block, oldest first
	lookup_rsp_t results_due [$];
	int          lookups_sent;
	int          error_count;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// overall time limit, far above the slowest legal run
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// expected outcome of one lookup, updating the shadow store as the block would
	function automatic lookup_rsp_t cache_lookup_predict(input lookup_req_t r);
		lookup_rsp_t res;
		int          hit_slot;
		int          free_slot;
		res       = '0;
		hit_slot  = -1;
		free_slot = -1;
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			if (hit_slot < 0 && model_valid[i] && model_inode[i] == r.inode_number &&
			    model_offset[i] == r.page_offset)
				hit_slot = i;
			if (free_slot < 0 && !model_valid[i])
				free_slot = i;
		end
		if (hit_slot >= 0) begin
			// a hit retags the entry with the new tier
			model_tier[hit_slot] = r.tier;
			res.status       = ST_HIT;
			res.slot_index   = SLOT_W'(hit_slot);
			res.frame_number = model_frame[hit_slot];
		end else if (free_slot < 0) begin
			res.status = ST_FULL;
		end else if (r.new_frame == '0) begin
			res.status = ST_NOFRAME;
		end else if (!r.fill_ok) begin
			res.status        = ST_FILLFAIL;
			res.release_frame = 1'b1;
		end else begin
			model_valid[free_slot]  = 1'b1;
			model_inode[free_slot]  = r.inode_number;
			model_offset[free_slot] = r.page_offset;
			model_frame[free_slot]  = r.new_frame;
			model_tier[free_slot]   = r.tier;
			fill_count++;
			res.status       = ST_FILLED;
			res.slot_index   = SLOT_W'(free_slot);
			res.frame_number = r.new_frame;
		end
		return res;
	endfunction

	function automatic lookup_req_t make_lookup(input logic [INODE_W-1:0] ino,
			input logic [OFFSET_W-1:0] off, input logic [TIER_W-1:0] tier,
			input logic [FRAME_W-1:0] frame, input logic ok);
		lookup_req_t r;
		r.inode_number = ino;
		r.page_offset  = off;
		r.tier         = tier;
		r.new_frame    = frame;
		r.fill_ok      = ok;
		return r;
	endfunction

	// called just after clk rises; returns as the request transfer takes place
	task automatic send_lookup(input lookup_req_t r);
		int send_idle_pct;
		send_idle_pct = (lookups_sent < PHASE_LEN) ? 33 :
		                (lookups_sent < 2 * PHASE_LEN) ? 48 : 0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.inode_number <= r.inode_number;
		req_ch.page_offset  <= r.page_offset;
		req_ch.tier         <= r.tier;
		req_ch.new_frame    <= r.new_frame;
		req_ch.fill_ok      <= r.fill_ok;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		results_due.push_back(cache_lookup_predict(r));
		lookups_sent++;
	endtask

	// key of a random filled slot, for lookups that should hit
	function automatic lookup_req_t cached_key(input lookup_req_t r);
		int k;
		k              = $urandom_range(0, fill_count - 1);
		r.inode_number = model_inode[k];
		r.page_offset  = model_offset[k];
		return r;
	endfunction

	function automatic lookup_req_t random_lookup();
		lookup_req_t r;
		r.inode_number = $urandom();
		r.page_offset  = $urandom();
		r.tier         = TIER_W'($urandom());
		r.new_frame    = FRAME_W'($urandom());
		r.fill_ok      = 1'($urandom());
		return r;
	endfunction

	// receiver stalls at random, in step with the sender's phases
	always @(posedge clk) begin
		if (lookups_sent < PHASE_LEN)
			rsp_ch.ready <= ($urandom_range(0, 99) >= 48);
		else if (lookups_sent < 2 * PHASE_LEN)
			rsp_ch.ready <= ($urandom_range(0, 99) >= 33);
		else
			rsp_ch.ready <= 1'b1;
	end

	// every result transfer is checked against the oldest expectation
	always @(posedge clk) begin : check_results
		lookup_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result with none due, status %0d",
					rsp_ch.status));
			end else begin
				want = results_due.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.slot_index !== want.slot_index)
					report_mismatch($sformatf("slot %0d, want %0d",
						rsp_ch.slot_index, want.slot_index));
				if (rsp_ch.frame_number !== want.frame_number)
					report_mismatch($sformatf("frame %h, want %h",
						rsp_ch.frame_number, want.frame_number));
				if (rsp_ch.release_frame !== want.release_frame)
					report_mismatch($sformatf("release %b, want %b",
						rsp_ch.release_frame, want.release_frame));
			end
		end
	end

	// extremes of the key, every status but full, and the priority of no frame over a failed fill
	task automatic test_directed();
		send_lookup(make_lookup('0, '0, 3'd0, 20'h00001, 1'b1));
		send_lookup(make_lookup('1, '1, 3'd7, 20'hFFFFF, 1'b1));
		// hits ignore the offered frame and the fill result
		send_lookup(make_lookup('0, '0, 3'd7, 20'h00000, 1'b0));
		send_lookup(make_lookup('1, '1, 3'd0, 20'hFFFFF, 1'b0));
		// no frame wins over a failed fill
		send_lookup(make_lookup('0, 32'd1, 3'd3, 20'h00000, 1'b1));
		send_lookup(make_lookup('0, 32'd1, 3'd3, 20'h00000, 1'b0));
		send_lookup(make_lookup('0, 32'd1, 3'd5, 20'h12345, 1'b0));
		// keys that share one half with a cached entry, then a repeat hit
		send_lookup(make_lookup('0, 32'd1, 3'd5, 20'hFFFFF, 1'b1));
		send_lookup(make_lookup(32'd1, '0, 3'd2, 20'h00001, 1'b1));
		send_lookup(make_lookup('1, '0, 3'd6, 20'h00000, 1'b1));
		send_lookup(make_lookup('1, '1, 3'd4, 20'h54321, 1'b1));
		// alternating bit patterns
		send_lookup(make_lookup(32'hAAAA_AAAA, 32'h5555_5555, 3'd5, 20'hAAAAA, 1'b1));
		send_lookup(make_lookup(32'h5555_5555, 32'hAAAA_AAAA, 3'd2, 20'h55555, 1'b1));
		send_lookup(make_lookup(32'hAAAA_AAAA, 32'h5555_5555, 3'd1, 20'h00000, 1'b0));
		send_lookup(make_lookup(32'h5555_5555, 32'hAAAA_AAAA, 3'd6, 20'h0F0F0, 1'b1));
		send_lookup(make_lookup(32'h5555_5555, 32'h5555_5555, 3'd3, 20'h0F0F0, 1'b0));
	endtask

	// random traffic while free slots remain, until the store is full
	task automatic test_fill_until_full();
		lookup_req_t r;
		lookup_req_t c;
		int          pick;
		while (fill_count < CACHE_SLOTS) begin
			r    = random_lookup();
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				r = cached_key(r);
			end else if (pick < 48) begin
				r.new_frame = '0;
			end else if (pick < 60) begin
				if (r.new_frame == '0)
					r.new_frame = 20'h00001;
				r.fill_ok = 1'b0;
			end else if (pick < 72) begin
				// near miss: one half of the key taken from a cached entry
				c              = cached_key(r);
				r.inode_number = c.inode_number;
				r.fill_ok      = 1'b1;
			end else if (pick < 80) begin
				c             = cached_key(r);
				r.page_offset = c.page_offset;
				r.fill_ok     = 1'b1;
			end else begin
				r.fill_ok = 1'b1;
			end
			send_lookup(r);
		end
	endtask

	// full store: misses report full whatever the frame, hits reach the first, the last and random slots
	task automatic test_full_cache();
		lookup_req_t r;
		lookup_req_t c;
		int          pick;
		send_lookup(make_lookup(32'h0000_1234, 32'h0000_5678, 3'd1, 20'h00000, 1'b0));
		send_lookup(make_lookup(32'h0000_1234, 32'h0000_5678, 3'd1, 20'hFFFFF, 1'b0));
		send_lookup(make_lookup(32'h0000_1234, 32'h0000_5678, 3'd1, 20'h00001, 1'b1));
		send_lookup(make_lookup(model_inode[CACHE_SLOTS-1], model_offset[CACHE_SLOTS-1],
			3'd7, 20'h00000, 1'b0));
		send_lookup(make_lookup(model_inode[0], model_offset[0], 3'd0, 20'hFFFFF, 1'b1));
		while (lookups_sent < TOTAL_LOOKUPS) begin
			r    = random_lookup();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				r = cached_key(r);
			end else if (pick < 75) begin
				c              = cached_key(r);
				r.inode_number = c.inode_number;
			end
			send_lookup(r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.inode_number <= '0;
		req_ch.page_offset  <= '0;
		req_ch.tier         <= '0;
		req_ch.new_frame    <= '0;
		req_ch.fill_ok      <= 1'b0;
		lookups_sent = 0;
		error_count  = 0;
		fill_count   = 0;
		for (int i = 0; i < CACHE_SLOTS; i++)
			model_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_until_full();
		test_full_cache();
		req_ch.valid <= 1'b0;

		// drain the outstanding results, then leave room for any stray transfer
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
